@@ design/wpm_pkg.sv @@
// shared types and constants for the wildcard pattern matcher
package wpm_pkg;

   localparam int FUNC_W = 2;
   localparam int SYMBOL_W = 8;
   localparam int LEN_W = 6;

   localparam logic [SYMBOL_W-1:0] STAR_CH = 8'h2A;
   localparam logic [SYMBOL_W-1:0] QMARK_CH = 8'h3F;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_START  = 2'd2,
      FUNC_TEXT   = 2'd3
   } func_type;

   // decoded command handed from the front to the back
   typedef struct packed {
      logic                clear;
      logic                append;
      logic                start;
      logic                text;
      logic [SYMBOL_W-1:0] symbol;
   } cmd_type;

endpackage

@@ design/wildcard_pattern_matcher.sv @@
// Wildcard pattern matcher ('?' any one char, '*' any run) over a streamed text.
// Takes one request beat per cycle while the command queue has room and returns
// one response beat per request; a request's response passes through the
// two-entry command queue and then the response register. Throughput is set
// by the back end's row update, whose longest path is the star OR ripple
// across the MAX_PAT match cells. Clear (func 0) empties the pattern and
// restarts the text, append (func 1) stores a character and restarts the text
// (a dropped append changes neither), start (func 2) restarts the text,
// and text (func 3) consumes one character. Each response reports whether the
// text since the last restart matches the whole pattern, the stored pattern
// length, and whether an append has been dropped since the last clear.
module wildcard_pattern_matcher #(
   parameter int MAX_PAT = 32,
   parameter int CHAR_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [wpm_pkg::FUNC_W-1:0]    req_func,
   input  logic [wpm_pkg::SYMBOL_W-1:0]  req_symbol,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_matched,
   output logic [wpm_pkg::LEN_W-1:0]     rsp_pattern_length,
   output logic                          rsp_pattern_full
);

   logic             q_valid;
   logic             q_ready;
   wpm_pkg::cmd_type q_cmd;

   wpm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_func   (req_func),
      .req_symbol (req_symbol),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_cmd      (q_cmd)
   );

   wpm_back #(
      .MAX_PAT   (MAX_PAT),
      .CHAR_BITS (CHAR_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_ready            (q_ready),
      .q_cmd              (q_cmd),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_matched        (rsp_matched),
      .rsp_pattern_length (rsp_pattern_length),
      .rsp_pattern_full   (rsp_pattern_full)
   );

endmodule

@@ design/wpm_front.sv @@
// front part: accepts request beats, decodes the function and queues commands
module wpm_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [wpm_pkg::FUNC_W-1:0]    req_func,
   input  logic [wpm_pkg::SYMBOL_W-1:0]  req_symbol,
   output logic                          q_valid,
   input  logic                          q_ready,
   output wpm_pkg::cmd_type              q_cmd
);

   wpm_pkg::cmd_type cmd_ff [2];
   wpm_pkg::cmd_type cmd_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             push, pop;

   always_comb begin
      cmd_in = '0;
      cmd_in.symbol = req_symbol;
      unique case (wpm_pkg::func_type'(req_func))
         wpm_pkg::FUNC_CLEAR:  cmd_in.clear = 1'b1;
         wpm_pkg::FUNC_APPEND: cmd_in.append = 1'b1;
         wpm_pkg::FUNC_START:  cmd_in.start = 1'b1;
         wpm_pkg::FUNC_TEXT:   cmd_in.text = 1'b1;
         default:              cmd_in.text = 1'b1;
      endcase
   end

   assign req_ready = (fill_ff != 2'd2);
   assign q_valid = (fill_ff != 2'd0);
   assign q_cmd = cmd_ff[rd_ptr_ff];
   assign push = req_valid && req_ready;
   assign pop = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_ff[wr_ptr_ff] <= cmd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_ff != 2'd3)
      else $error("queue fill out of range");

endmodule

@@ design/wpm_back.sv @@
// back part: pattern store, match row cells and the response register
module wpm_back #(
   parameter int MAX_PAT = 32,
   parameter int CHAR_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  wpm_pkg::cmd_type              q_cmd,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_matched,
   output logic [wpm_pkg::LEN_W-1:0]     rsp_pattern_length,
   output logic                          rsp_pattern_full
);

   localparam int CNT_W = $clog2(MAX_PAT + 1);
   localparam int ROW_W = MAX_PAT + 1;
   localparam int EXT_W = CNT_W + wpm_pkg::LEN_W;
   localparam int SYM_EXT_W = CHAR_BITS + wpm_pkg::SYMBOL_W;
   localparam logic [CHAR_BITS-1:0] STAR_C = CHAR_BITS'(wpm_pkg::STAR_CH);
   localparam logic [CHAR_BITS-1:0] QMARK_C = CHAR_BITS'(wpm_pkg::QMARK_CH);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAT);

   logic [CHAR_BITS-1:0] store_ff [MAX_PAT];
   logic [CHAR_BITS-1:0] store_in [MAX_PAT];
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 ovf_ff, ovf_in;
   logic [ROW_W-1:0]     row_ff, row_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 matched_ff, matched_in;
   logic [wpm_pkg::LEN_W-1:0] len_ff, len_in;
   logic                 full_ff, full_in;

   logic                 fire;
   logic                 append_ok;
   logic [SYM_EXT_W-1:0] sym_ext;
   logic [CHAR_BITS-1:0] sym_c;
   logic [MAX_PAT-1:0]   lit_cell;
   logic [MAX_PAT-1:0]   star_cell;
   logic [ROW_W-1:0]     init_row;
   logic [ROW_W-1:0]     text_row;
   logic [EXT_W-1:0]     count_ext;

   assign q_ready = !rsp_valid_ff || rsp_ready;
   assign fire = q_valid && q_ready;
   assign sym_ext = SYM_EXT_W'(q_cmd.symbol);
   assign sym_c = sym_ext[CHAR_BITS-1:0];
   assign append_ok = q_cmd.append && !ovf_ff && (count_ff < CNT_MAX);

   // per-cell compare of the stored character against the text character
   always_comb begin
      for (int i = 0; i < MAX_PAT; i++) begin
         lit_cell[i] = (store_ff[i] == sym_c) || (store_ff[i] == QMARK_C);
         star_cell[i] = (store_ff[i] == STAR_C);
      end
   end

   always_comb begin
      for (int i = 0; i < MAX_PAT; i++) begin
         store_in[i] = store_ff[i];
         if (append_ok && (count_ff == CNT_W'(i))) begin
            store_in[i] = sym_c;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      ovf_in = ovf_ff;
      if (q_cmd.clear) begin
         count_in = '0;
         ovf_in = 1'b0;
      end else if (append_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (q_cmd.append) begin
         ovf_in = 1'b1;
      end
   end

   // initial row: leading run of stars of the pattern as it will stand
   always_comb begin
      logic run;
      run = 1'b1;
      init_row = '0;
      init_row[0] = 1'b1;
      for (int j = 1; j <= MAX_PAT; j++) begin
         run = run && (store_in[j-1] == STAR_C);
         init_row[j] = run && (CNT_W'(j) <= count_in);
      end
   end

   // one text character: diagonal step where the cell equals it or is '?', star ripple on '*', zero otherwise
   always_comb begin
      text_row = '0;
      for (int j = 1; j <= MAX_PAT; j++) begin
         if (CNT_W'(j) > count_ff) begin
            text_row[j] = 1'b0;
         end else if (lit_cell[j-1]) begin
            text_row[j] = row_ff[j-1];
         end else if (star_cell[j-1]) begin
            text_row[j] = row_ff[j] || text_row[j-1];
         end else begin
            text_row[j] = 1'b0;
         end
      end
   end

   always_comb begin
      priority if (q_cmd.text) begin
         row_in = text_row;
      end else if (q_cmd.clear || q_cmd.start || append_ok) begin
         row_in = init_row;
      end else begin
         row_in = row_ff;
      end
   end

   always_comb begin
      matched_in = 1'b0;
      for (int j = 0; j <= MAX_PAT; j++) begin
         if (count_in == CNT_W'(j)) begin
            matched_in = row_in[j];
         end
      end
      count_ext = EXT_W'(count_in);
      len_in = count_ext[wpm_pkg::LEN_W-1:0];
      full_in = ovf_in;
      rsp_valid_in = fire ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         store_ff <= store_in;
         matched_ff <= matched_in;
         len_ff <= len_in;
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
         row_ff <= ROW_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            count_ff <= count_in;
            ovf_ff <= ovf_in;
            row_ff <= row_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_matched = matched_ff;
   assign rsp_pattern_length = len_ff;
   assign rsp_pattern_full = full_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("pattern count beyond store depth");

   assert property (@(posedge clock) disable iff (reset)
      fire && q_cmd.clear |=> count_ff == '0 && !ovf_ff && row_ff[0])
      else $error("clear did not reset pattern state");

   assert property (@(posedge clock) disable iff (reset)
      fire && q_cmd.append && !ovf_ff && (count_ff < CNT_MAX)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("stored append did not advance count");

   assert property (@(posedge clock) disable iff (reset)
      fire && q_cmd.text |=> !row_ff[0])
      else $error("text beat left row bit zero set");

   assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("executed command produced no response");

endmodule
